// ===== design/scp_pkg.sv =====
// Shared types and constants for the serial command byte parser.
package scp_pkg;

  localparam int MAX_CHARS = 16;
  localparam int IDX_W     = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_M    = 8'h6d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] MODE_COUNT = 8'd3;

  localparam logic [2:0] KIND_RAW      = 3'd0;
  localparam logic [2:0] KIND_CHAR     = 3'd1;
  localparam logic [2:0] KIND_MODE     = 3'd2;
  localparam logic [2:0] KIND_OVERFLOW = 3'd3;
  localparam logic [2:0] KIND_EMPTY    = 3'd4;

  typedef enum logic [2:0] {
    OP_RAW,
    OP_STORE,
    OP_FLUSH,
    OP_MODE,
    OP_OVERFLOW,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CAPTURE,
    F_MODE
  } fstate_t;

  typedef enum logic {
    B_IDLE,
    B_READ
  } bstate_t;

endpackage

// ===== design/scp_front.sv =====
// Front end: takes received bytes, tracks the command parser, issues commands.
module scp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                bypass_enable,
  input  logic                push,
  input  logic [7:0]          rx_byte,
  input  logic                q_full,
  output logic                cmd_wr,
  output scp_pkg::cmd_t       cmd
);

  scp_pkg::fstate_t state, state_next;
  logic [scp_pkg::CNT_W-1:0] count, count_next;
  logic bypass_mode;
  logic accept;
  logic is_term;
  logic is_digit;

  assign accept   = push && !q_full;
  assign is_term  = (rx_byte == scp_pkg::CH_LF) || (rx_byte == scp_pkg::CH_CR);
  assign is_digit = (rx_byte >= scp_pkg::CH_ZERO) &&
                    (rx_byte < scp_pkg::CH_ZERO + scp_pkg::MODE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= scp_pkg::F_IDLE;
      count       <= '0;
      bypass_mode <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_write) begin
        bypass_mode <= bypass_enable;
      end
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    if (accept && !bypass_mode) begin
      case (state)
        scp_pkg::F_IDLE: begin
          if (rx_byte == scp_pkg::CH_S) begin
            state_next = scp_pkg::F_CAPTURE;
          end else if (rx_byte == scp_pkg::CH_M) begin
            state_next = scp_pkg::F_MODE;
          end
        end
        scp_pkg::F_CAPTURE: begin
          if (is_term || count == scp_pkg::CNT_W'(scp_pkg::MAX_CHARS)) begin
            count_next = '0;
            state_next = scp_pkg::F_IDLE;
          end else begin
            count_next = count + 1'b1;
          end
        end
        default: begin
          state_next = scp_pkg::F_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_wr     = 1'b0;
    cmd.op     = scp_pkg::OP_RAW;
    cmd.data   = rx_byte;
    cmd.count  = count;
    if (accept) begin
      if (bypass_mode) begin
        cmd_wr = 1'b1;
      end else begin
        case (state)
          scp_pkg::F_CAPTURE: begin
            cmd_wr = 1'b1;
            if (is_term) begin
              cmd.op = (count == '0) ? scp_pkg::OP_EMPTY : scp_pkg::OP_FLUSH;
            end else if (count == scp_pkg::CNT_W'(scp_pkg::MAX_CHARS)) begin
              cmd.op = scp_pkg::OP_OVERFLOW;
            end else begin
              cmd.op = scp_pkg::OP_STORE;
            end
          end
          scp_pkg::F_MODE: begin
            cmd_wr   = is_digit;
            cmd.op   = scp_pkg::OP_MODE;
            cmd.data = rx_byte - scp_pkg::CH_ZERO;
          end
          default: begin
            cmd_wr = 1'b0;
          end
        endcase
      end
    end
  end

endmodule

// ===== design/scp_cmd_queue.sv =====
// Short command queue between the front end and the back end.
module scp_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  scp_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output scp_pkg::cmd_t rd_data,
  output logic          empty
);

  scp_pkg::cmd_t entries [scp_pkg::QDEPTH];
  logic [scp_pkg::QPTR_W-1:0] wptr;
  logic [scp_pkg::QPTR_W-1:0] rptr;
  logic [scp_pkg::QCNT_W-1:0] fill;
  logic do_wr;
  logic do_rd;

  assign full    = (fill == scp_pkg::QCNT_W'(scp_pkg::QDEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_data;
    end
  end

endmodule

// ===== design/scp_back.sv =====
// Back end: holds the string store and turns commands into result beats.
module scp_back (
  input  logic                clk,
  input  logic                rst,
  input  scp_pkg::cmd_t       cmd,
  input  logic                cmd_empty,
  output logic                cmd_take,
  input  logic                pop,
  output logic                empty,
  output logic [2:0]          result_kind,
  output logic [7:0]          result_byte,
  output logic                last
);

  logic [7:0] store [scp_pkg::MAX_CHARS];
  logic [7:0] rd_data;

  scp_pkg::bstate_t state, state_next;
  logic [scp_pkg::IDX_W-1:0] idx, idx_next;
  logic [scp_pkg::CNT_W-1:0] rd_count, rd_count_next;
  logic [scp_pkg::CNT_W-1:0] wcount, wcount_next;

  logic       out_valid;
  logic       out_free;
  logic       emit;
  logic [2:0] emit_kind;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic       store_wr;
  logic       read_last;

  assign out_free  = !out_valid || pop;
  assign read_last = (scp_pkg::CNT_W'(idx) + 1'b1) == rd_count;

  always_comb begin
    state_next = state;
    case (state)
      scp_pkg::B_IDLE: begin
        if (!cmd_empty && cmd.op == scp_pkg::OP_FLUSH) begin
          state_next = scp_pkg::B_READ;
        end
      end
      scp_pkg::B_READ: begin
        if (out_free && read_last) begin
          state_next = scp_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = scp_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_take      = 1'b0;
    emit          = 1'b0;
    emit_kind     = scp_pkg::KIND_RAW;
    emit_byte     = cmd.data;
    emit_last     = 1'b1;
    store_wr      = 1'b0;
    idx_next      = '0;
    rd_count_next = rd_count;
    wcount_next   = wcount;
    case (state)
      scp_pkg::B_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            scp_pkg::OP_STORE: begin
              cmd_take    = 1'b1;
              store_wr    = 1'b1;
              wcount_next = wcount + 1'b1;
            end
            scp_pkg::OP_FLUSH: begin
              cmd_take      = 1'b1;
              rd_count_next = cmd.count;
              wcount_next   = '0;
            end
            scp_pkg::OP_MODE: begin
              cmd_take  = out_free;
              emit      = out_free;
              emit_kind = scp_pkg::KIND_MODE;
            end
            scp_pkg::OP_OVERFLOW: begin
              cmd_take    = out_free;
              emit        = out_free;
              emit_kind   = scp_pkg::KIND_OVERFLOW;
              emit_byte   = '0;
              if (out_free) begin
                wcount_next = '0;
              end
            end
            scp_pkg::OP_EMPTY: begin
              cmd_take  = out_free;
              emit      = out_free;
              emit_kind = scp_pkg::KIND_EMPTY;
              emit_byte = '0;
            end
            default: begin
              cmd_take  = out_free;
              emit      = out_free;
              emit_kind = scp_pkg::KIND_RAW;
            end
          endcase
        end
      end
      scp_pkg::B_READ: begin
        emit_kind = scp_pkg::KIND_CHAR;
        emit_byte = rd_data;
        emit_last = read_last;
        emit      = out_free;
        if (out_free) begin
          idx_next = read_last ? '0 : idx + 1'b1;
        end else begin
          idx_next = idx;
        end
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= scp_pkg::B_IDLE;
      idx       <= '0;
      rd_count  <= '0;
      wcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      rd_count <= rd_count_next;
      wcount   <= wcount_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind <= emit_kind;
      result_byte <= emit_byte;
      last        <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store[wcount[scp_pkg::IDX_W-1:0]] <= cmd.data;
    end
    rd_data <= store[idx_next];
  end

  assign empty = !out_valid;

`ifndef SYNTH
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == scp_pkg::B_READ) |-> (scp_pkg::CNT_W'(idx) < rd_count))
    else $error("read index past string length");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.op == scp_pkg::OP_STORE) |->
      (wcount < scp_pkg::CNT_W'(scp_pkg::MAX_CHARS)))
    else $error("store beyond capacity");

  a_flush_count: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.op == scp_pkg::OP_FLUSH) |->
      (cmd.count == wcount && cmd.count != '0))
    else $error("flush count differs from stored characters");

  a_last_char_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_kind == scp_pkg::KIND_CHAR && emit_last) |=>
      (state == scp_pkg::B_IDLE))
    else $error("readout continues after last character");
`endif

endmodule

// ===== design/serial_command_byte_parser.sv =====
// Top level of the serial command byte parser.
//
// Input side is a queue: drive rx_byte with push; a beat is taken when push
// is high and full is low. Result side is a queue too: while empty is low the
// oldest result sits on result_kind, result_byte and last; pop takes it.
// bypass_enable is loaded when cfg_write is high; the user must do so only
// while the block is idle, which the block itself does not enforce. With the
// command queue empty, a byte that yields one result shows after the command
// queue entry and the back-end output register. A CR or LF ending a capture
// of N characters gives N results, one per cycle while pop is held, the first
// after the queue entry, the store read register and the output register; the
// readout holds the back end in its read state to the last character. Other
// bytes are taken while the four-entry command queue has room, so the front end
// keeps taking bytes during a string readout until that queue fills. The string
// store has one read port, which sets the one character per cycle readout.
// Reset clears parser state, the queue, the output register and bypass mode.
// When pop is held low, the output register holds, the back end stops at the
// next result command, the queue fills, and full rises to stall the sender.
module serial_command_byte_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       bypass_enable,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] result_kind,
  output logic [7:0] result_byte,
  output logic       last
);

  scp_pkg::cmd_t wr_cmd;
  scp_pkg::cmd_t rd_cmd;
  logic          cmd_wr;
  logic          cmd_take;
  logic          q_empty;

  scp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .bypass_enable (bypass_enable),
    .push          (push),
    .rx_byte       (rx_byte),
    .q_full        (full),
    .cmd_wr        (cmd_wr),
    .cmd           (wr_cmd)
  );

  scp_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (wr_cmd),
    .full    (full),
    .rd_en   (cmd_take),
    .rd_data (rd_cmd),
    .empty   (q_empty)
  );

  scp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (rd_cmd),
    .cmd_empty   (q_empty),
    .cmd_take    (cmd_take),
    .pop         (pop),
    .empty       (empty),
    .result_kind (result_kind),
    .result_byte (result_byte),
    .last        (last)
  );

endmodule

// ===== tb/serial_command_byte_parser_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the serial command byte parser: directed table, then random traffic.
module serial_command_byte_parser_test;
  import scp_pkg::*;

  localparam int LIMIT        = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic       bypass;
    logic [7:0] rx;
    logic [4:0] reps;
    logic       typed;
    logic [2:0] kind;
    logic [7:0] data;
  } dir_row_t;

  typedef struct packed {
    logic bypass;
    int   gap;
    int   stall;
    int   items;
  } phase_t;

  localparam int DIR_ROW_COUNT = 24;
  localparam dir_row_t DIR_ROWS [DIR_ROW_COUNT] = '{
    '{1'b0, 8'h78,   5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, CH_S,    5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, CH_CR,   5'd1,  1'b1, KIND_EMPTY,    8'h00},
    '{1'b0, CH_M,    5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, CH_ZERO, 5'd1,  1'b1, KIND_MODE,     8'h00},
    '{1'b0, CH_M,    5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, 8'h32,   5'd1,  1'b1, KIND_MODE,     8'h02},
    '{1'b0, CH_M,    5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, 8'h31,   5'd1,  1'b1, KIND_MODE,     8'h01},
    '{1'b0, CH_M,    5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, 8'h33,   5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, CH_S,    5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, 8'h00,   5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, 8'hff,   5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, CH_LF,   5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, CH_S,    5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, 8'h61,   5'd16, 1'b0, KIND_RAW,      8'h00},
    '{1'b0, 8'h62,   5'd1,  1'b1, KIND_OVERFLOW, 8'h00},
    '{1'b0, CH_S,    5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b0, 8'h63,   5'd16, 1'b0, KIND_RAW,      8'h00},
    '{1'b0, CH_CR,   5'd1,  1'b0, KIND_RAW,      8'h00},
    '{1'b1, 8'h00,   5'd1,  1'b1, KIND_RAW,      8'h00},
    '{1'b1, 8'hff,   5'd1,  1'b1, KIND_RAW,      8'hff},
    '{1'b1, CH_S,    5'd1,  1'b1, KIND_RAW,      CH_S}
  };

  localparam int PHASE_COUNT = 6;
  localparam phase_t PHASES [PHASE_COUNT] = '{
    '{1'b0, 0,  0,  90},
    '{1'b1, 87, 0,  25},
    '{1'b0, 87, 0,  75},
    '{1'b0, 0,  87, 75},
    '{1'b1, 18, 18, 25},
    '{1'b0, 18, 18, 90}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       bypass_enable = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] result_kind;
  logic [7:0] result_byte;
  logic       last;

  serial_command_byte_parser uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .bypass_enable(bypass_enable),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (result_kind),
    .result_byte  (result_byte),
    .last         (last)
  );

  always #4 clk = ~clk;

  // parser shadow state
  logic       model_bypass = 1'b0;
  fstate_t    model_state = F_IDLE;
  logic [7:0] model_chars [MAX_CHARS];
  int         model_count = 0;

  beat_t pending_beats [$];
  int    gap_pct = 0;
  int    stall_pct = 0;
  int    errors = 0;
  int    cycle_count = 0;
  int    phase_items = 0;
  beat_t got_beat;
  beat_t want_beat;

  task automatic predict_byte(input logic [7:0] b, output beat_t beats [$], output bit ignored);
    beats = {};
    ignored = 1'b0;
    if (model_bypass) begin
      beats.push_back('{KIND_RAW, b, 1'b1});
      return;
    end
    case (model_state)
      F_IDLE: begin
        if (b == CH_S) model_state = F_CAPTURE;
        else if (b == CH_M) model_state = F_MODE;
        else ignored = 1'b1;
      end
      F_CAPTURE: begin
        if (b == CH_LF || b == CH_CR) begin
          if (model_count == 0) begin
            beats.push_back('{KIND_EMPTY, 8'h00, 1'b1});
          end else begin
            for (int i = 0; i < model_count; i++)
              beats.push_back('{KIND_CHAR, model_chars[i], (i == model_count - 1)});
          end
          model_count = 0;
          model_state = F_IDLE;
        end else if (model_count < MAX_CHARS) begin
          model_chars[model_count] = b;
          model_count++;
        end else begin
          model_count = 0;
          model_state = F_IDLE;
          beats.push_back('{KIND_OVERFLOW, 8'h00, 1'b1});
        end
      end
      F_MODE: begin
        if (b >= CH_ZERO && b < CH_ZERO + MODE_COUNT)
          beats.push_back('{KIND_MODE, b - CH_ZERO, 1'b1});
        model_state = F_IDLE;
      end
      default: model_state = F_IDLE;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed, input logic [2:0] kind,
                           input logic [7:0] data, output bit ignored);
    beat_t step_beats [$];
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full !== 1'b0);
    predict_byte(b, step_beats, ignored);
    if (typed) pending_beats.push_back('{kind, data, 1'b1});
    else foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
  endtask

  task automatic push_byte(input logic [7:0] b);
    bit ignored;
    send_byte(b, 1'b0, KIND_RAW, 8'h00, ignored);
    if (!ignored) phase_items++;
  endtask

  // block must be drained before the register changes
  task automatic write_bypass(input logic v);
    @(negedge clk);
    push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    bypass_enable <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    model_bypass = v;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CH_LF || b == CH_CR) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic send_string();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 60) len = $urandom_range(4);
    else if (r < 80) len = $urandom_range(15, 5);
    else if (r < 90) len = MAX_CHARS;
    else len = MAX_CHARS + 1;
    push_byte(CH_S);
    for (int i = 0; i < len; i++) push_byte(text_byte());
    if (len <= MAX_CHARS) push_byte($urandom_range(1) ? CH_CR : CH_LF);
  endtask

  task automatic flag_beat(input string what, input beat_t want, input beat_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch (%s): expected kind %0d byte %02h last %0b, %s",
               what, want.kind, want.data, want.last,
               $sformatf("got kind %0d byte %02h last %0b", got.kind, got.data, got.last));
  endtask

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && empty === 1'b0) begin
      got_beat = '{result_kind, result_byte, last};
      if (pending_beats.size() == 0) begin
        flag_beat("unexpected beat", '0, got_beat);
      end else begin
        want_beat = pending_beats.pop_front();
        if (got_beat.kind !== want_beat.kind) flag_beat("result_kind", want_beat, got_beat);
        else if (got_beat.data !== want_beat.data) flag_beat("result_byte", want_beat, got_beat);
        else if (got_beat.last !== want_beat.last) flag_beat("last", want_beat, got_beat);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("serial_command_byte_parser_test: FAIL");
      $finish;
    end
  end

  initial begin
    bit ignored;
    int r;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIR_ROW_COUNT; n++) begin
      if (DIR_ROWS[n].bypass != model_bypass) write_bypass(DIR_ROWS[n].bypass);
      repeat (DIR_ROWS[n].reps)
        send_byte(DIR_ROWS[n].rx, DIR_ROWS[n].typed, DIR_ROWS[n].kind, DIR_ROWS[n].data,
                  ignored);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (PHASES[p].bypass != model_bypass) write_bypass(PHASES[p].bypass);
      gap_pct = PHASES[p].gap;
      stall_pct = PHASES[p].stall;
      phase_items = 0;
      while (phase_items < PHASES[p].items) begin
        if (model_bypass) begin
          push_byte(8'($urandom_range(255)));
        end else begin
          r = $urandom_range(99);
          if (r < 45) begin
            send_string();
          end else if (r < 75) begin
            push_byte(CH_M);
            push_byte($urandom_range(99) < 80 ? CH_ZERO + 8'($urandom_range(2))
                                              : 8'($urandom_range(255)));
          end else begin
            push_byte(8'($urandom_range(255)));
          end
        end
      end
    end

    @(negedge clk);
    push <= 1'b0;
    stall_pct = 0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("serial_command_byte_parser_test: PASS");
    end else begin
      $display("serial_command_byte_parser_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/scp_pkg.sv
design/scp_front.sv
design/scp_cmd_queue.sv
design/scp_back.sv
design/serial_command_byte_parser.sv
tb/serial_command_byte_parser_test.sv
